// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl files, included by the top-level module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent on the same edge
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// condition must never be seen
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== hw/rtl/i2cagu_pkg.sv =====
package i2cagu_pkg;

    // geometry limits
    localparam int MAX_DIM    = 1024;
    localparam int MAX_KERNEL = 16;
    localparam int MAX_BATCH  = 256;

    // field and register widths
    localparam int DIM_W    = 11;
    localparam int BATCH_W  = 9;
    localparam int KERN_W   = 5;
    localparam int SRC_W    = 38;
    localparam int DST_W    = 46;

    // stream and config port widths
    localparam int TDATA_IN_W   = 8;
    localparam int TDATA_OUT_W  = 88;
    localparam int TUSER_W      = 1;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 11;
    localparam int IN_RESTART_BIT = 0;

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // divider for output rows/cols
    localparam int DIVD_W     = 10;
    localparam int DIV_STEPS  = DIVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // shared multiply-add unit
    localparam int MAC_A_W   = 29;
    localparam int MAC_B_W   = 18;
    localparam int MAC_ADD_W = 28;
    localparam int MAC_M_W   = MAC_A_W + MAC_B_W;
    localparam int MAC_P_W   = MAC_M_W + 1;

    // register indexes of the config port
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IMG_HEIGHT    = 3'd0,
        CFG_IMG_WIDTH     = 3'd1,
        CFG_NUM_CHANNELS  = 3'd2,
        CFG_BATCH_SIZE    = 3'd3,
        CFG_KERNEL_HEIGHT = 3'd4,
        CFG_KERNEL_WIDTH  = 3'd5,
        CFG_STRIDE        = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   img_height;
        logic [DIM_W-1:0]   img_width;
        logic [DIM_W-1:0]   num_channels;
        logic [BATCH_W-1:0] batch_size;
        logic [KERN_W-1:0]  kernel_height;
        logic [KERN_W-1:0]  kernel_width;
        logic [KERN_W-1:0]  stride;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        img_height:    11'd1,
        img_width:     11'd1,
        num_channels:  11'd1,
        batch_size:    9'd1,
        kernel_height: 5'd1,
        kernel_width:  5'd1,
        stride:        5'd1
    };

    // command classes held in the queue
    typedef enum logic [0:0] {
        CMD_ADVANCE = 1'b0,
        CMD_RESTART = 1'b1
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_word;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [KERN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_H,
        ST_DIV_W,
        ST_MAC,
        ST_OUT
    } t_bstate;

    // multiply-add steps, in issue order
    typedef enum logic [3:0] {
        OP_NT,
        OP_TOT,
        OP_BC,
        OP_ROW,
        OP_COL,
        OP_SRC1,
        OP_SRC,
        OP_OR,
        OP_ORW,
        OP_OC,
        OP_OCOL,
        OP_DST
    } t_op;

    // zero reads as one, too large reads as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > CFG_DATA_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    function automatic logic [BATCH_W-1:0] clamp_batch(input logic [CFG_DATA_W-1:0] v);
        logic [BATCH_W-1:0] res;
        if (v == '0) begin
            res = BATCH_W'(1);
        end else if (v > CFG_DATA_W'(MAX_BATCH)) begin
            res = BATCH_W'(MAX_BATCH);
        end else begin
            res = BATCH_W'(v);
        end
        return res;
    endfunction

    function automatic logic [KERN_W-1:0] clamp_kern(input logic [CFG_DATA_W-1:0] v);
        logic [KERN_W-1:0] res;
        if (v == '0) begin
            res = KERN_W'(1);
        end else if (v > CFG_DATA_W'(MAX_KERNEL)) begin
            res = KERN_W'(MAX_KERNEL);
        end else begin
            res = KERN_W'(v);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/i2cagu_front.sv =====
module i2cagu_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] restart, [7:1] zero fill
    input  logic [i2cagu_pkg::TDATA_IN_W-1:0] s_axis_tdata,
    input  logic                              i_pop,
    output i2cagu_pkg::t_q_word               o_q
);
    import i2cagu_pkg::*;

    t_cmd             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wptr;
    logic [Q_AW-1:0]  r_rptr;
    logic [Q_AW:0]    r_count;
    logic             w_push;
    t_cmd             w_cmd;

    // classify the incoming word
    assign w_cmd = s_axis_tdata[IN_RESTART_BIT] ? CMD_RESTART : CMD_ADVANCE;

    assign s_axis_tready = (r_count != (Q_AW+1)'(Q_DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // command storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_cmd;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.cmd   = r_mem[r_rptr];

endmodule

// ===== hw/rtl/i2cagu_div.sv =====
module i2cagu_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cagu_pkg::t_div_req i_req,
    output i2cagu_pkg::t_div_rsp o_rsp
);
    import i2cagu_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVD_W-1:0]    r_quo;
    logic [KERN_W-1:0]    r_rem;
    logic [KERN_W-1:0]    r_dvs;
    logic [KERN_W:0]      w_rem_sh;
    logic                 w_fit;
    logic [KERN_W-1:0]    w_rem_nx;

    // one restoring step per cycle
    assign w_rem_sh = {r_rem, r_quo[DIVD_W-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_dvs});
    assign w_rem_nx = w_fit ? KERN_W'(w_rem_sh - {1'b0, r_dvs}) : KERN_W'(w_rem_sh);

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient shifts in as dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], w_fit};
            r_rem <= w_rem_nx;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== hw/rtl/i2cagu_back.sv =====
module i2cagu_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  i2cagu_pkg::t_cfg             i_cfg,
    input  logic                         i_cfg_wr,
    input  logic                         i_shape_err,
    input  i2cagu_pkg::t_q_word          i_q,
    output logic                         o_pop,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [i2cagu_pkg::SRC_W-1:0] o_src_index,
    output logic [i2cagu_pkg::DST_W-1:0] o_dst_index,
    output logic                         o_last,
    output logic                         o_shape_error
);
    import i2cagu_pkg::*;

    function automatic t_op next_op(input t_op op);
        t_op res;
        case (op)
            OP_NT:   res = OP_TOT;
            OP_TOT:  res = OP_BC;
            OP_BC:   res = OP_ROW;
            OP_ROW:  res = OP_COL;
            OP_COL:  res = OP_SRC1;
            OP_SRC1: res = OP_SRC;
            OP_SRC:  res = OP_OR;
            OP_OR:   res = OP_ORW;
            OP_ORW:  res = OP_OC;
            OP_OC:   res = OP_OCOL;
            OP_OCOL: res = OP_DST;
            default: res = OP_DST;
        endcase
        return res;
    endfunction

    t_bstate r_state, n_state;
    t_op     r_op, n_op;

    // walk position
    logic [7:0] r_batch_count;
    logic [9:0] r_chan_count;
    logic [9:0] r_win_row;
    logic [9:0] r_win_col;
    logic [3:0] r_kern_row;
    logic [3:0] r_kern_col;
    logic       r_walk_done;

    // geometry
    logic             r_geo_ok;
    logic [DIM_W-1:0] r_oh;
    logic [DIM_W-1:0] r_ow;
    logic             r_err;

    // partial products
    logic [17:0] r_bc;
    logic [13:0] r_row;
    logic [13:0] r_col;
    logic [28:0] r_src1;
    logic [SRC_W-1:0] r_src;
    logic [13:0] r_or;
    logic [17:0] r_orow;
    logic [17:0] r_oc;
    logic [27:0] r_ocol;
    logic [18:0] r_nt;
    logic [28:0] r_tot;
    logic [DST_W-1:0] r_dst;

    // output register
    logic             r_out_valid;
    logic [SRC_W-1:0] r_out_src;
    logic [DST_W-1:0] r_out_dst;
    logic             r_out_last;
    logic             r_out_err;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic                 w_load_out;
    logic                 w_out_free;
    logic [DIVD_W-1:0]    w_h_room;
    logic [DIVD_W-1:0]    w_w_room;
    logic [MAC_A_W-1:0]   w_a;
    logic [MAC_B_W-1:0]   w_b;
    logic [MAC_ADD_W-1:0] w_add;
    logic [MAC_M_W-1:0]   w_mul;
    logic [MAC_P_W-1:0]   w_mac;
    logic w_kc_wrap, w_kr_wrap, w_wc_wrap, w_wr_wrap, w_ch_wrap, w_b_wrap;
    logic w_c1, w_c2, w_c3, w_c4, w_c5;
    logic w_is_last;

    i2cagu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // room left for the window, to be divided by the stride
    assign w_h_room = DIVD_W'(i_cfg.img_height - DIM_W'(i_cfg.kernel_height));
    assign w_w_room = DIVD_W'(i_cfg.img_width - DIM_W'(i_cfg.kernel_width));

    assign w_out_free = !r_out_valid || i_tready;

    // counter carries, same test as the end-of-walk check
    assign w_kc_wrap = ((KERN_W'(r_kern_col) + KERN_W'(1)) >= i_cfg.kernel_width);
    assign w_kr_wrap = ((KERN_W'(r_kern_row) + KERN_W'(1)) >= i_cfg.kernel_height);
    assign w_wc_wrap = ((DIM_W'(r_win_col) + DIM_W'(1)) >= r_ow);
    assign w_wr_wrap = ((DIM_W'(r_win_row) + DIM_W'(1)) >= r_oh);
    assign w_ch_wrap = ((DIM_W'(r_chan_count) + DIM_W'(1)) >= i_cfg.num_channels);
    assign w_b_wrap  = ((BATCH_W'(r_batch_count) + BATCH_W'(1)) >= i_cfg.batch_size);
    assign w_c1 = w_kc_wrap;
    assign w_c2 = w_c1 && w_kr_wrap;
    assign w_c3 = w_c2 && w_wc_wrap;
    assign w_c4 = w_c3 && w_wr_wrap;
    assign w_c5 = w_c4 && w_ch_wrap;
    assign w_is_last = w_c5 && w_b_wrap;

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_h_room;
        w_div_req.divisor  = i_cfg.stride;
        case (r_state)
            ST_IDLE: begin
                if (i_q.valid) begin
                    o_pop = 1'b1;
                    if (i_shape_err) begin
                        n_state = ST_OUT;
                    end else if (!r_geo_ok) begin
                        w_div_req.start = 1'b1;
                        n_state         = ST_DIV_H;
                    end else begin
                        n_op    = OP_BC;
                        n_state = ST_MAC;
                    end
                end
            end
            ST_DIV_H: begin
                w_div_req.dividend = w_w_room;
                if (w_div_rsp.done) begin
                    w_div_req.start = 1'b1;
                    n_state         = ST_DIV_W;
                end
            end
            ST_DIV_W: begin
                if (w_div_rsp.done) begin
                    n_op    = OP_NT;
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_op == OP_DST) begin
                    n_state = ST_OUT;
                end else begin
                    n_op = next_op(r_op);
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_BC;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // operand select for the multiply-add
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_add = '0;
        case (r_op)
            OP_NT: begin
                w_a = MAC_A_W'(r_oh);
                w_b = MAC_B_W'(i_cfg.batch_size);
            end
            OP_TOT: begin
                w_a = MAC_A_W'(r_nt);
                w_b = MAC_B_W'(r_ow);
            end
            OP_BC: begin
                w_a   = MAC_A_W'(i_cfg.num_channels);
                w_b   = MAC_B_W'(r_batch_count);
                w_add = MAC_ADD_W'(r_chan_count);
            end
            OP_ROW: begin
                w_a   = MAC_A_W'(i_cfg.stride);
                w_b   = MAC_B_W'(r_win_row);
                w_add = MAC_ADD_W'(r_kern_row);
            end
            OP_COL: begin
                w_a   = MAC_A_W'(i_cfg.stride);
                w_b   = MAC_B_W'(r_win_col);
                w_add = MAC_ADD_W'(r_kern_col);
            end
            OP_SRC1: begin
                w_a   = MAC_A_W'(r_bc);
                w_b   = MAC_B_W'(i_cfg.img_height);
                w_add = MAC_ADD_W'(r_row);
            end
            OP_SRC: begin
                w_a   = MAC_A_W'(r_src1);
                w_b   = MAC_B_W'(i_cfg.img_width);
                w_add = MAC_ADD_W'(r_col);
            end
            OP_OR: begin
                w_a   = MAC_A_W'(i_cfg.kernel_height);
                w_b   = MAC_B_W'(r_chan_count);
                w_add = MAC_ADD_W'(r_kern_row);
            end
            OP_ORW: begin
                w_a   = MAC_A_W'(r_or);
                w_b   = MAC_B_W'(i_cfg.kernel_width);
                w_add = MAC_ADD_W'(r_kern_col);
            end
            OP_OC: begin
                w_a   = MAC_A_W'(r_oh);
                w_b   = MAC_B_W'(r_batch_count);
                w_add = MAC_ADD_W'(r_win_row);
            end
            OP_OCOL: begin
                w_a   = MAC_A_W'(r_oc);
                w_b   = MAC_B_W'(r_ow);
                w_add = MAC_ADD_W'(r_win_col);
            end
            OP_DST: begin
                w_a   = MAC_A_W'(r_tot);
                w_b   = MAC_B_W'(r_orow);
                w_add = MAC_ADD_W'(r_ocol);
            end
            default: begin
                w_a   = '0;
                w_b   = '0;
                w_add = '0;
            end
        endcase
    end

    assign w_mul = MAC_M_W'(w_a) * MAC_M_W'(w_b);
    assign w_mac = MAC_P_W'(w_mul) + MAC_P_W'(w_add);

    // partial product registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MAC) begin
            case (r_op)
                OP_NT:   r_nt   <= w_mac[18:0];
                OP_TOT:  r_tot  <= w_mac[28:0];
                OP_BC:   r_bc   <= w_mac[17:0];
                OP_ROW:  r_row  <= w_mac[13:0];
                OP_COL:  r_col  <= w_mac[13:0];
                OP_SRC1: r_src1 <= w_mac[28:0];
                OP_SRC:  r_src  <= w_mac[SRC_W-1:0];
                OP_OR:   r_or   <= w_mac[13:0];
                OP_ORW:  r_orow <= w_mac[17:0];
                OP_OC:   r_oc   <= w_mac[17:0];
                OP_OCOL: r_ocol <= w_mac[27:0];
                OP_DST:  r_dst  <= w_mac[DST_W-1:0];
                default: r_dst  <= r_dst;
            endcase
        end
    end

    // output rows and columns from the divider
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV_H && w_div_rsp.done) begin
            r_oh <= DIM_W'(w_div_rsp.quotient) + DIM_W'(1);
        end
        if (r_state == ST_DIV_W && w_div_rsp.done) begin
            r_ow <= DIM_W'(w_div_rsp.quotient) + DIM_W'(1);
        end
        if (o_pop) begin
            r_err <= i_shape_err;
        end
    end

    // geometry goes stale on any config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geo_ok <= 1'b0;
        end else if (i_cfg_wr) begin
            r_geo_ok <= 1'b0;
        end else if (r_state == ST_MAC && r_op == OP_TOT) begin
            r_geo_ok <= 1'b1;
        end
    end

    // walk counters: restart when a restart word is popped, advance when the word is handed out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && i_q.cmd == CMD_RESTART)) begin
            r_batch_count <= '0;
            r_chan_count  <= '0;
            r_win_row     <= '0;
            r_win_col     <= '0;
            r_kern_row    <= '0;
            r_kern_col    <= '0;
            r_walk_done   <= 1'b0;
        end else if (w_load_out && !r_err && !r_walk_done) begin
            if (w_is_last) begin
                r_walk_done <= 1'b1;
            end else begin
                r_kern_col <= w_kc_wrap ? '0 : r_kern_col + 1'b1;
                if (w_c1) begin
                    r_kern_row <= w_kr_wrap ? '0 : r_kern_row + 1'b1;
                end
                if (w_c2) begin
                    r_win_col <= w_wc_wrap ? '0 : r_win_col + 1'b1;
                end
                if (w_c3) begin
                    r_win_row <= w_wr_wrap ? '0 : r_win_row + 1'b1;
                end
                if (w_c4) begin
                    r_chan_count <= w_ch_wrap ? '0 : r_chan_count + 1'b1;
                end
                if (w_c5) begin
                    r_batch_count <= w_b_wrap ? '0 : r_batch_count + 1'b1;
                end
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_src  <= r_err ? '0 : r_src;
            r_out_dst  <= r_err ? '0 : r_dst;
            r_out_last <= r_err || r_walk_done || w_is_last;
            r_out_err  <= r_err;
        end
    end

    assign o_tvalid      = r_out_valid;
    assign o_src_index   = r_out_src;
    assign o_dst_index   = r_out_dst;
    assign o_last        = r_out_last;
    assign o_shape_error = r_out_err;

endmodule

// ===== hw/rtl/im2col_address_generator_unit.sv =====
// im2col index generator for a batch of NCHW images. Each input word advances the walk by
// one pair (or restarts it at the first pair) and yields the flat source index into the image
// tensor and the flat destination index into the row-major column matrix; the final pair
// carries tlast, and a kernel larger than the image gives a zero pair with tuser and tlast set.
// A normal word pulls the command from a two-entry queue, runs ten steps of the single shared
// multiply-add unit that builds both indices, and loads the output register. A shape-error
// word goes straight to the output register. The first word after any config write runs two
// 10-step serial divisions for the output rows and columns and two more multiply-add steps for
// the column-matrix width. The queue keeps taking words while it has room, also while the back
// end computes or waits on a stalled output. Config writes are only legal while idle.
`include "assert_macros.svh"

module im2col_address_generator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] restart, [7:1] zero fill
    input  logic [i2cagu_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [37:0] src_index, [83:38] dst_index, [87:84] zero fill
    output logic [i2cagu_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    output logic                               m_axis_tlast,
    // [0] shape_error
    output logic [i2cagu_pkg::TUSER_W-1:0]     m_axis_tuser,
    // config write port
    input  logic                               i_cfg_we,
    input  logic [i2cagu_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [i2cagu_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import i2cagu_pkg::*;

    t_cfg             r_cfg;
    t_q_word          w_q;
    logic             w_pop;
    logic             w_shape_err;
    logic [SRC_W-1:0] w_src;
    logic [DST_W-1:0] w_dst;
    logic             w_shape_flag;

    // config registers, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IMG_HEIGHT:    r_cfg.img_height    <= clamp_dim(i_cfg_wdata);
                CFG_IMG_WIDTH:     r_cfg.img_width     <= clamp_dim(i_cfg_wdata);
                CFG_NUM_CHANNELS:  r_cfg.num_channels  <= clamp_dim(i_cfg_wdata);
                CFG_BATCH_SIZE:    r_cfg.batch_size    <= clamp_batch(i_cfg_wdata);
                CFG_KERNEL_HEIGHT: r_cfg.kernel_height <= clamp_kern(i_cfg_wdata);
                CFG_KERNEL_WIDTH:  r_cfg.kernel_width  <= clamp_kern(i_cfg_wdata);
                CFG_STRIDE:        r_cfg.stride        <= clamp_kern(i_cfg_wdata);
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    // kernel does not fit the image
    assign w_shape_err = (DIM_W'(r_cfg.kernel_height) > r_cfg.img_height) ||
                         (DIM_W'(r_cfg.kernel_width) > r_cfg.img_width);

    i2cagu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_pop         (w_pop),
        .o_q           (w_q)
    );

    i2cagu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cfg_wr      (i_cfg_we),
        .i_shape_err   (w_shape_err),
        .i_q           (w_q),
        .o_pop         (w_pop),
        .o_tvalid      (m_axis_tvalid),
        .i_tready      (m_axis_tready),
        .o_src_index   (w_src),
        .o_dst_index   (w_dst),
        .o_last        (m_axis_tlast),
        .o_shape_error (w_shape_flag)
    );

    // pack the output word
    assign m_axis_tdata = {(TDATA_OUT_W - SRC_W - DST_W)'(0), w_dst, w_src};
    assign m_axis_tuser = TUSER_W'(w_shape_flag);

    // checks
    `ASSERT_NEVER(a_pop_when_empty, i_clk, i_rst_n, w_pop && !w_q.valid)
    `ASSERT_IMPLY(a_err_is_last, i_clk, i_rst_n, m_axis_tvalid && w_shape_flag, m_axis_tlast && (w_src == '0) && (w_dst == '0))
    `ASSERT_IMPLY(a_err_matches_cfg, i_clk, i_rst_n, m_axis_tvalid && w_shape_flag, w_shape_err)

endmodule
